>>> design/ppat_pkg.sv
// Shared types and constants of the page pool allocator and translator.
// No dependencies; all design files but ppat_ram use its scoped names.
package ppat_pkg;

  localparam int unsigned PAGE_COUNT_DEF = 16;
  localparam int unsigned PAGE_ORDER_DEF = 15;

  localparam int unsigned VA_W     = 32;
  localparam int unsigned SIZE_W   = 32;
  localparam int unsigned PA_W     = 40;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned INDEX_W  = 4;
  localparam int unsigned FREED_W  = 5;
  localparam int unsigned APB_AW   = 4;
  localparam int unsigned APB_DW   = 64;

  // register index, taken from paddr[3]
  localparam logic REG_PHYS_BASE = 1'b0;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_XLATE   = 2'd2,
    OP_RECYCLE = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NO_PAGE   = 3'd1,
    ST_BAD_SIZE  = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_MAP_FAIL  = 3'd4
  } status_e;

endpackage

>>> design/ppat_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ppat_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> design/page_pool_allocator_translate_core.sv
// Top level of the page pool allocator and translator.
// Depends on ppat_pkg and ppat_ram (recorded virtual address per page).
//
// The block manages PAGE_COUNT pages of 2**PAGE_ORDER bytes placed back to back
// from phys_base (APB register at byte address 0). Each request (alloc, free,
// translate, recycle) gives exactly one result. Requests are handled one at a
// time: the page table is walked one entry per cycle through the read port of
// the address RAM, stopping at the first hit. A miss or a recycle walks every
// entry, and an alloc with a bad size skips the walk. Occupancy flags live in
// flip-flops cleared by reset, so no clearing pass runs after reset. A new
// request is taken as soon as the previous one has moved into the output
// register, even while that result still waits to be taken.
module page_pool_allocator_translate_core #(
  parameter int unsigned PAGE_COUNT = ppat_pkg::PAGE_COUNT_DEF,
  parameter int unsigned PAGE_ORDER = ppat_pkg::PAGE_ORDER_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ppat_pkg::APB_AW-1:0]     paddr,
  input  logic [ppat_pkg::APB_DW-1:0]     pwdata,
  output logic [ppat_pkg::APB_DW-1:0]     prdata,
  output logic                            pready,
  // request
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      opcode_i,
  input  logic [ppat_pkg::VA_W-1:0]       virt_addr_i,
  input  logic [ppat_pkg::SIZE_W-1:0]     request_size_i,
  input  logic                            map_ok_i,
  // result
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [ppat_pkg::STATUS_W-1:0]   status_o,
  output logic [ppat_pkg::PA_W-1:0]       phys_addr_o,
  output logic [ppat_pkg::INDEX_W-1:0]    page_index_o,
  output logic [ppat_pkg::FREED_W-1:0]    freed_count_o
);

  localparam int unsigned IW      = PAGE_COUNT > 1 ? $clog2(PAGE_COUNT) : 1;
  localparam int unsigned CW      = $clog2(PAGE_COUNT + 1);
  localparam int unsigned IdxExtW = IW + ppat_pkg::INDEX_W;
  localparam int unsigned CntExtW = CW + ppat_pkg::FREED_W;
  localparam logic [IW-1:0] LastIdx = IW'(PAGE_COUNT - 1);
  localparam logic [ppat_pkg::SIZE_W-1:0] PageBytes = ppat_pkg::SIZE_W'(1) << PAGE_ORDER;
  localparam logic [ppat_pkg::PA_W-1:0]   PageStep  = ppat_pkg::PA_W'(1) << PAGE_ORDER;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  logic [1:0]                    state_q, state_d;
  logic [ppat_pkg::PA_W-1:0]     phys_base_q, phys_base_d;
  logic [PAGE_COUNT-1:0]         occ_q, occ_d;
  ppat_pkg::op_e                 op_q, op_d;
  logic [ppat_pkg::VA_W-1:0]     va_q, va_d;
  logic                          map_ok_q, map_ok_d;
  logic [IW-1:0]                 rd_idx_q, rd_idx_d;
  logic                          rd_go_q, rd_go_d;
  logic [IW-1:0]                 ev_idx_q, ev_idx_d;
  logic                          ev_vld_q, ev_vld_d;
  logic [ppat_pkg::PA_W-1:0]     pp_q, pp_d;
  logic [CW-1:0]                 cnt_q, cnt_d;

  logic [ppat_pkg::STATUS_W-1:0] res_status_q, res_status_d;
  logic [ppat_pkg::PA_W-1:0]     res_phys_q, res_phys_d;
  logic [ppat_pkg::INDEX_W-1:0]  res_index_q, res_index_d;
  logic [ppat_pkg::FREED_W-1:0]  res_freed_q, res_freed_d;

  logic                          out_vld_q, out_vld_d;
  logic [ppat_pkg::STATUS_W-1:0] status_q, status_d;
  logic [ppat_pkg::PA_W-1:0]     phys_q, phys_d;
  logic [ppat_pkg::INDEX_W-1:0]  index_q, index_d;
  logic [ppat_pkg::FREED_W-1:0]  freed_q, freed_d;

  logic                          mem_we;
  logic                          mem_re;
  logic [ppat_pkg::VA_W-1:0]     mem_rdata;

  logic                          ev_occ;
  logic [ppat_pkg::VA_W-1:0]     ev_virt;
  logic [ppat_pkg::VA_W:0]       ev_diff;
  logic                          ev_in_page;
  logic [ppat_pkg::VA_W-1:0]     ev_xlate;
  logic                          ev_last;
  logic [IdxExtW-1:0]            ev_idx_ext;
  logic [CW-1:0]                 cnt_inc;
  logic [CntExtW-1:0]            cnt_ext;
  logic                          out_free;
  logic                          cfg_wr;

  ppat_ram #(
    .WIDTH (ppat_pkg::VA_W),
    .DEPTH (PAGE_COUNT)
  ) u_virt_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (ev_idx_q),
    .wdata_i (va_q),
    .re_i    (mem_re),
    .raddr_i (rd_idx_q),
    .rdata_o (mem_rdata)
  );

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[3] == ppat_pkg::REG_PHYS_BASE)
                ? ppat_pkg::APB_DW'(phys_base_q) : '0;
  assign phys_base_d = (cfg_wr && paddr[3] == ppat_pkg::REG_PHYS_BASE)
                     ? pwdata[ppat_pkg::PA_W-1:0] : phys_base_q;

  // a free page always reads as address zero
  assign ev_occ     = occ_q[ev_idx_q];
  assign ev_virt    = ev_occ ? mem_rdata : '0;
  assign ev_diff    = {1'b0, va_q} - {1'b0, ev_virt};
  assign ev_in_page = !ev_diff[ppat_pkg::VA_W]
                   && (ev_diff[ppat_pkg::VA_W-1:PAGE_ORDER] == '0);
  assign ev_xlate   = pp_q[ppat_pkg::VA_W-1:0] + ev_diff[ppat_pkg::VA_W-1:0];
  assign ev_last    = (ev_idx_q == LastIdx);
  assign ev_idx_ext = IdxExtW'(ev_idx_q);
  assign cnt_inc    = cnt_q + CW'(ev_occ);
  assign cnt_ext    = CntExtW'(cnt_inc);
  assign mem_re     = (state_q == S_SCAN) && rd_go_q;
  assign out_free   = !out_vld_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d      = state_q;
    occ_d        = occ_q;
    op_d         = op_q;
    va_d         = va_q;
    map_ok_d     = map_ok_q;
    rd_idx_d     = rd_idx_q;
    rd_go_d      = rd_go_q;
    ev_idx_d     = ev_idx_q;
    ev_vld_d     = ev_vld_q;
    pp_d         = pp_q;
    cnt_d        = cnt_q;
    res_status_d = res_status_q;
    res_phys_d   = res_phys_q;
    res_index_d  = res_index_q;
    res_freed_d  = res_freed_q;
    out_vld_d    = out_vld_q && !out_ready_i;
    status_d     = status_q;
    phys_d       = phys_q;
    index_d      = index_q;
    freed_d      = freed_q;
    mem_we       = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d         = ppat_pkg::op_e'(opcode_i);
          va_d         = virt_addr_i;
          map_ok_d     = map_ok_i;
          pp_d         = phys_base_q;
          cnt_d        = '0;
          rd_idx_d     = '0;
          ev_vld_d     = 1'b0;
          res_status_d = ppat_pkg::ST_NOT_FOUND;
          res_phys_d   = '0;
          res_index_d  = '0;
          res_freed_d  = '0;
          if (ppat_pkg::op_e'(opcode_i) == ppat_pkg::OP_ALLOC && request_size_i != PageBytes) begin
            res_status_d = ppat_pkg::ST_BAD_SIZE;
            rd_go_d      = 1'b0;
            state_d      = S_RESP;
          end else begin
            rd_go_d      = 1'b1;
            state_d      = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // issue the next read, evaluate the entry read last cycle
        if (rd_go_q) begin
          ev_idx_d = rd_idx_q;
          ev_vld_d = 1'b1;
          rd_idx_d = rd_idx_q + IW'(1);
          rd_go_d  = (rd_idx_q != LastIdx);
        end else begin
          ev_vld_d = 1'b0;
        end
        if (ev_vld_q) begin
          pp_d = pp_q + PageStep;
          unique case (op_q)
            ppat_pkg::OP_ALLOC: begin
              if (!ev_occ) begin
                state_d     = S_RESP;
                res_index_d = ev_idx_ext[ppat_pkg::INDEX_W-1:0];
                if (map_ok_q) begin
                  occ_d[ev_idx_q] = 1'b1;
                  mem_we          = 1'b1;
                  res_status_d    = ppat_pkg::ST_OK;
                  res_phys_d      = pp_q;
                end else begin
                  res_status_d    = ppat_pkg::ST_MAP_FAIL;
                end
              end else if (ev_last) begin
                state_d      = S_RESP;
                res_status_d = ppat_pkg::ST_NO_PAGE;
              end
            end
            ppat_pkg::OP_FREE: begin
              if (ev_virt == va_q) begin
                state_d = S_RESP;
                if (ev_occ) begin
                  occ_d[ev_idx_q] = 1'b0;
                  res_status_d    = ppat_pkg::ST_OK;
                  res_index_d     = ev_idx_ext[ppat_pkg::INDEX_W-1:0];
                end
              end else if (ev_last) begin
                state_d = S_RESP;
              end
            end
            ppat_pkg::OP_XLATE: begin
              if (ev_in_page) begin
                state_d      = S_RESP;
                res_status_d = ppat_pkg::ST_OK;
                res_index_d  = ev_idx_ext[ppat_pkg::INDEX_W-1:0];
                res_phys_d   = ppat_pkg::PA_W'(ev_xlate);
              end else if (ev_last) begin
                state_d = S_RESP;
              end
            end
            ppat_pkg::OP_RECYCLE: begin
              occ_d[ev_idx_q] = 1'b0;
              cnt_d           = cnt_inc;
              if (ev_last) begin
                state_d      = S_RESP;
                res_status_d = ppat_pkg::ST_OK;
                res_freed_d  = cnt_ext[ppat_pkg::FREED_W-1:0];
              end
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
          if (state_d == S_RESP) begin
            rd_go_d  = 1'b0;
            ev_vld_d = 1'b0;
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          status_d  = res_status_q;
          phys_d    = res_phys_q;
          index_d   = res_index_q;
          freed_d   = res_freed_q;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phys_base_q <= '0;
      occ_q       <= '0;
      rd_go_q     <= 1'b0;
      ev_vld_q    <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      phys_base_q <= phys_base_d;
      occ_q       <= occ_d;
      rd_go_q     <= rd_go_d;
      ev_vld_q    <= ev_vld_d;
      out_vld_q   <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    va_q         <= va_d;
    map_ok_q     <= map_ok_d;
    rd_idx_q     <= rd_idx_d;
    ev_idx_q     <= ev_idx_d;
    pp_q         <= pp_d;
    cnt_q        <= cnt_d;
    res_status_q <= res_status_d;
    res_phys_q   <= res_phys_d;
    res_index_q  <= res_index_d;
    res_freed_q  <= res_freed_d;
    status_q     <= status_d;
    phys_q       <= phys_d;
    index_q      <= index_d;
    freed_q      <= freed_d;
  end

  assign out_valid_o   = out_vld_q;
  assign status_o      = status_q;
  assign phys_addr_o   = phys_q;
  assign page_index_o  = index_q;
  assign freed_count_o = freed_q;

endmodule

>>> design/ppat_chk.sv
// Port-level checker for the page pool allocator, bound to the top level.
// Depends on ppat_pkg and page_pool_allocator_translate_core.
module ppat_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [ppat_pkg::STATUS_W-1:0] status_o,
  input logic [ppat_pkg::PA_W-1:0]     phys_addr_o,
  input logic [ppat_pkg::INDEX_W-1:0]  page_index_o,
  input logic [ppat_pkg::FREED_W-1:0]  freed_count_o
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(phys_addr_o) && $stable(page_index_o) && $stable(freed_count_o))
    else $error("stalled result changed");

  // one request at a time
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while busy");

  a_fail_no_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ppat_pkg::ST_OK |-> phys_addr_o == '0 && freed_count_o == '0)
    else $error("failed request carries an address or count");

  a_recycle_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && freed_count_o != '0 |-> phys_addr_o == '0 && page_index_o == '0)
    else $error("recycle result carries an address or index");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o == ppat_pkg::ST_OK || status_o == ppat_pkg::ST_NO_PAGE
      || status_o == ppat_pkg::ST_BAD_SIZE || status_o == ppat_pkg::ST_NOT_FOUND
      || status_o == ppat_pkg::ST_MAP_FAIL)
    else $error("undefined status code");

endmodule

bind page_pool_allocator_translate_core ppat_chk u_ppat_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .status_o      (status_o),
  .phys_addr_o   (phys_addr_o),
  .page_index_o  (page_index_o),
  .freed_count_o (freed_count_o)
);
